[src/swp_pkg.sv]
// ----------------------------------------------------------------------------
// swp_pkg
// Shared constants and controller/datapath interface types for the
// sliding-window percentile filter.
// ----------------------------------------------------------------------------
package swp_pkg;

    localparam int WINDOW_SIZE = 32;
    localparam int IDX_W       = $clog2(WINDOW_SIZE);
    localparam int CNT_W       = 6;
    localparam int SAMPLE_W    = 16;
    localparam int PCT_W       = 7;

    // percentile * (count-1)
    localparam int PROD_W      = PCT_W + IDX_W;
    // divide by 100 as multiply by 2^19/100 rounded up; exact for PROD_W bits
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_W     = 13;
    localparam int QPROD_W     = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int QUOT_W      = QPROD_W - RECIP_SHIFT;

    // APB
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam logic REG_PERCENTILE = 1'b0;
    localparam logic [PCT_W-1:0] PERCENTILE_RESET = 7'd50;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic capture;    // take the input transfer
        logic ring_read;  // fetch oldest sample
        logic remove;     // drop oldest sample from sorted cells
        logic insert;     // insert new sample, write ring
        logic median;     // read median, form percentile product
        logic pct_index;  // scale product by 1/100
        logic pct_read;   // read percentile element
        logic load_out;   // move result to output register
    } swp_cmd_t;

    typedef struct packed {
        logic full;       // window holds WINDOW_SIZE samples
        logic out_free;   // output register can take a result
    } swp_status_t;

endpackage

[src/swp_ctrl.sv]
// ----------------------------------------------------------------------------
// swp_ctrl
// Sequencer: walks one sample through ring read and remove (if full), insert,
// two order-statistic reads, then hands the result to the output register.
// ----------------------------------------------------------------------------
module swp_ctrl
    import swp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  swp_status_t status,
    output swp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RING,
        ST_REMOVE,
        ST_INSERT,
        ST_MEDIAN,
        ST_PIDX,
        ST_PCT,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = status.full ? ST_RING : ST_INSERT;
                end
            end
            ST_RING:
            begin
                cmd.ring_read = 1'b1;
                state_next    = ST_REMOVE;
            end
            ST_REMOVE:
            begin
                cmd.remove = 1'b1;
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = ST_MEDIAN;
            end
            ST_MEDIAN:
            begin
                cmd.median = 1'b1;
                state_next = ST_PIDX;
            end
            ST_PIDX:
            begin
                cmd.pct_index = 1'b1;
                state_next    = ST_PCT;
            end
            ST_PCT:
            begin
                cmd.pct_read = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[src/swp_datapath.sv]
// ----------------------------------------------------------------------------
// swp_datapath
// Sample ring memory, compare-and-shift sorted cell array, order-statistic
// index arithmetic and the output register.
// ----------------------------------------------------------------------------
module swp_datapath
    import swp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  swp_cmd_t            cmd,
    output swp_status_t         status,
    input  logic [PCT_W-1:0]    percentile,
    input  sample_t             sample,
    output logic                out_valid,
    input  logic                out_ready,
    output sample_t             median_value,
    output sample_t             percentile_value,
    output logic [CNT_W-1:0]    held_count
);

    sample_t              ring_mem [WINDOW_SIZE];
    sample_t              cell_reg [WINDOW_SIZE];
    sample_t              cell_next [WINDOW_SIZE];

    sample_t              sample_reg;
    sample_t              oldest_reg;
    sample_t              med_reg;
    sample_t              pct_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [IDX_W-1:0]     pidx_reg;
    logic [IDX_W-1:0]     wr_idx_reg;
    logic [CNT_W-1:0]     fill_reg;

    logic                 out_valid_reg;
    sample_t              out_med_reg;
    sample_t              out_pct_reg;
    logic [CNT_W-1:0]     out_cnt_reg;

    logic [CNT_W-1:0]     last_cnt;
    logic [IDX_W-1:0]     last_idx;
    logic [IDX_W-1:0]     rd_idx;
    sample_t              rd_data;
    logic [QPROD_W-1:0]   qprod;
    logic [QUOT_W-1:0]    quot;
    logic [WINDOW_SIZE-1:0] gt;

    assign status.full     = (fill_reg == CNT_W'(WINDOW_SIZE));
    assign status.out_free = !out_valid_reg || out_ready;

    assign last_cnt = fill_reg - CNT_W'(1);
    assign last_idx = last_cnt[IDX_W-1:0];

    // one shared read port on the cell array
    assign rd_idx  = cmd.median ? (last_idx >> 1) : pidx_reg;
    assign rd_data = cell_reg[rd_idx];

    assign qprod = QPROD_W'(prod_reg) * QPROD_W'(RECIP_100);
    assign quot  = qprod[QPROD_W-1:RECIP_SHIFT];

    // Cell update. Remove: cells at or above the leaving value pull from the
    // right. Insert: cells greater than the new value push right, the first
    // of them (or the slot at fill) takes the new value.
    always_comb
    begin
        for (int j = 0; j < WINDOW_SIZE; j++)
        begin
            gt[j] = (CNT_W'(j) < fill_reg) && (cell_reg[j] > sample_reg);
        end
        for (int j = 0; j < WINDOW_SIZE; j++)
        begin
            cell_next[j] = cell_reg[j];
            if (cmd.remove)
            begin
                if ((j < WINDOW_SIZE - 1) && (CNT_W'(j + 1) < fill_reg)
                    && (cell_reg[j] >= oldest_reg))
                begin
                    cell_next[j] = cell_reg[(j + 1) % WINDOW_SIZE];
                end
            end
            else if (cmd.insert)
            begin
                if (gt[j] || (CNT_W'(j) == fill_reg))
                begin
                    if ((j > 0) && gt[(j + WINDOW_SIZE - 1) % WINDOW_SIZE])
                    begin
                        cell_next[j] = cell_reg[(j + WINDOW_SIZE - 1) % WINDOW_SIZE];
                    end
                    else
                    begin
                        cell_next[j] = sample_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < WINDOW_SIZE; j++)
        begin
            cell_reg[j] <= cell_next[j];
        end
    end

    // ring memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            ring_mem[wr_idx_reg] <= sample_reg;
        end
        if (cmd.ring_read)
        begin
            oldest_reg <= ring_mem[wr_idx_reg];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample;
        end
        if (cmd.median)
        begin
            med_reg  <= rd_data;
            prod_reg <= PROD_W'(percentile) * PROD_W'(last_idx);
        end
        if (cmd.pct_index)
        begin
            pidx_reg <= (quot > QUOT_W'(last_idx)) ? last_idx : quot[IDX_W-1:0];
        end
        if (cmd.pct_read)
        begin
            pct_reg <= rd_data;
        end
        if (cmd.load_out)
        begin
            out_med_reg <= med_reg;
            out_pct_reg <= pct_reg;
            out_cnt_reg <= fill_reg;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            wr_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.remove)
            begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
            else if (cmd.insert)
            begin
                fill_reg   <= fill_reg + CNT_W'(1);
                wr_idx_reg <= wr_idx_reg + IDX_W'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign median_value     = out_med_reg;
    assign percentile_value = out_pct_reg;
    assign held_count       = out_cnt_reg;

endmodule

[src/sliding_window_percentile.sv]
// ----------------------------------------------------------------------------
// sliding_window_percentile
// Rank-order filter over the last 32 signed samples: lower median and a
// configurable percentile after every sample.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready, sample): one 16-bit signed sample per
// transfer. Output channel (out_valid/out_ready): one result per sample with
// median_value, percentile_value and held_count (samples held, up to 32).
// APB register 0 (byte address 0): percentile, 7 bits, reset 50; values above
// 100 report the largest sample held. Write it only while the block is idle.
// After the input transfer the sequencer steps through insert, median read,
// percentile index, percentile read and done before out_valid rises; once the
// window is full, the oldest sample is first read from the ring and removed
// from the sorted cells. One sample is in work at a time: in_ready is low
// until the sequencer, which steps one sample through ring read, remove,
// insert and two reads on the single cell-array read port, is idle again.
// The output register parts the channels: the next sample is taken while a
// result still waits. If the receiver stalls longer, the finished result
// waits in the sequencer and in_ready stays low until it can move on.
// Reset clears the window count, the ring pointer and out_valid; the register
// returns to 50. No clearing pass is needed.
// ----------------------------------------------------------------------------
module sliding_window_percentile
    import swp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sample_t             sample,
    output logic                out_valid,
    input  logic                out_ready,
    output sample_t             median_value,
    output sample_t             percentile_value,
    output logic [CNT_W-1:0]    held_count,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    swp_cmd_t          cmd;
    swp_status_t       status;
    logic [PCT_W-1:0]  percentile_reg;
    logic              reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1] == REG_PERCENTILE);
    assign prdata  = reg_hit ? PDATA_W'(percentile_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            percentile_reg <= PERCENTILE_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            percentile_reg <= pwdata[PCT_W-1:0];
        end
    end

    swp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    swp_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .percentile       (percentile_reg),
        .sample           (sample),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .median_value     (median_value),
        .percentile_value (percentile_value),
        .held_count       (held_count)
    );

endmodule

[src/swp_checker.sv]
// ----------------------------------------------------------------------------
// swp_checker
// Port-level checks for the sliding-window percentile filter.
// ----------------------------------------------------------------------------
module swp_checker
    import swp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  sample_t             median_value,
    input  sample_t             percentile_value,
    input  logic [CNT_W-1:0]    held_count
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(median_value)
            && $stable(percentile_value) && $stable(held_count))
        else $error("output changed while stalled");

    // count is never zero and never beyond the window
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (held_count != '0) && (held_count <= CNT_W'(WINDOW_SIZE)))
        else $error("held_count out of range");

    // one sample at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a sample is in work");

    // no result appears right after a transfer
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result too early");

endmodule

bind sliding_window_percentile swp_checker u_swp_checker (.*);

[bench/swp_rank_checker.sv]
// ----------------------------------------------------------------------------
// swp_rank_checker
// Watches the sample, result and register ports of the sliding-window
// percentile filter. Keeps its own window of the last WINDOW_SIZE samples
// (arrival ring plus sorted copy), predicts the median, percentile value and
// held count for every accepted sample, and compares each result transfer
// against the oldest prediction.
// ----------------------------------------------------------------------------
module swp_rank_checker
    import swp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  sample_t             sample,
    input  logic                out_valid,
    input  logic                out_ready,
    input  sample_t             median_value,
    input  sample_t             percentile_value,
    input  logic [CNT_W-1:0]    held_count,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    input  logic                pready,
    output int                  pending,
    output int                  errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [PADDR_W-1:0] PCT_ADDR = PADDR_W'(4 * REG_PERCENTILE);

    typedef struct packed {
        sample_t            median;
        sample_t            pct_value;
        logic [CNT_W-1:0]   count;
    } rank_result_t;

    sample_t            ring_samples [WINDOW_SIZE];
    sample_t            sorted_samples [WINDOW_SIZE];
    int                 ring_ptr;
    int                 held;
    logic [PCT_W-1:0]   pct_cfg;
    rank_result_t       expected_ranks [$];
    int                 err_n = 0;

    // Slide the window by one sample and return the order statistics.
    function automatic rank_result_t window_rank_update(input sample_t s);
        rank_result_t r;
        int pos;
        int last;
        int pidx;
        if (held >= WINDOW_SIZE) begin
            // drop one copy of the oldest sample; scan down so the lowest match wins
            pos = held - 1;
            for (int i = held - 1; i >= 0; i--)
                if (sorted_samples[i] == ring_samples[ring_ptr])
                    pos = i;
            for (int i = pos; i < held - 1; i++)
                sorted_samples[i] = sorted_samples[i + 1];
            held--;
        end
        pos = held;
        while (pos > 0 && sorted_samples[pos - 1] > s) begin
            sorted_samples[pos] = sorted_samples[pos - 1];
            pos--;
        end
        sorted_samples[pos] = s;
        held++;
        ring_samples[ring_ptr] = s;
        ring_ptr = (ring_ptr + 1) % WINDOW_SIZE;

        last = held - 1;
        pidx = (int'(pct_cfg) * last) / 100;
        if (pidx > last)
            pidx = last;
        r.median    = sorted_samples[last / 2];
        r.pct_value = sorted_samples[pidx];
        r.count     = CNT_W'(held);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rank_result_t want;
        if (!rst_n)
        begin
            held     = 0;
            ring_ptr = 0;
            pct_cfg  = PERCENTILE_RESET;
            expected_ranks.delete();
            pending <= 0;
            errors  <= err_n;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == PCT_ADDR)
                pct_cfg = pwdata[PCT_W-1:0];

            if (in_valid && in_ready)
                expected_ranks.push_back(window_rank_update(sample));

            if (out_valid && out_ready)
            begin
                if (expected_ranks.size() == 0)
                begin
                    $error("result transfer with none expected: median_value %0d", median_value);
                    err_n++;
                end
                else
                begin
                    want = expected_ranks.pop_front();
                    if (median_value !== want.median)
                    begin
                        $error("median_value: expected %0d, got %0d", want.median, median_value);
                        err_n++;
                    end
                    if (percentile_value !== want.pct_value)
                    begin
                        $error("percentile_value: expected %0d, got %0d",
                               want.pct_value, percentile_value);
                        err_n++;
                    end
                    if (held_count !== want.count)
                    begin
                        $error("held_count: expected %0d, got %0d", want.count, held_count);
                        err_n++;
                    end
                end
            end
            pending <= expected_ranks.size();
            errors  <= err_n;
        end
    end

endmodule

[bench/sliding_window_percentile_tb.sv]
// ----------------------------------------------------------------------------
// sliding_window_percentile_tb
// Drives signed samples into the rank-order filter through the valid/ready
// input channel, with random sender gaps and receiver stalls, and walks the
// percentile register through its extremes between phases. Checking is done
// by swp_rank_checker; this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module sliding_window_percentile_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import swp_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 43;
    localparam logic [PADDR_W-1:0] PCT_ADDR = PADDR_W'(4 * REG_PERCENTILE);

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    sample_t            sample = '0;
    logic               out_valid;
    logic               out_ready = 1'b1;
    sample_t            median_value;
    sample_t            percentile_value;
    logic [CNT_W-1:0]   held_count;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int                 pending;
    int                 errors;
    bit                 idle_on = 1'b1;
    int                 stall_left = 0;
    int                 quiet = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sliding_window_percentile dut (.*);

    swp_rank_checker rank_check (.*);

    // receiver stalls in bursts, started at random while idle_on is set
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 15);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("** sliding_window_percentile: FAILED **");
            $finish;
        end
    end

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return sample_t'($urandom);
            5, 6:          return sample_t'(int'($urandom_range(0, 6)) - 3);
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       return sample_t'(16'h8000);
                    1:       return sample_t'(16'h7FFF);
                    2:       return sample_t'(16'h0000);
                    default: return sample_t'(16'hFFFF);
                endcase
            end
            default:       return sample_t'(int'($urandom_range(0, 255)) - 128);
        endcase
    endfunction

    // one sample transfer; returns just after the accepting edge
    task automatic send_sample(input sample_t s);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // hold off the sender until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_percentile(input logic [PCT_W-1:0] pct);
        logic [PDATA_W-1:0] w;
        w = $urandom;
        w[PCT_W-1:0] = pct;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PCT_ADDR;
        pwdata  <= w;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        logic [PCT_W-1:0] pct_plan [$];
        pct_plan = '{7'd0, 7'd100, 7'd127, 7'd101, 7'd1, 7'd99, 7'd50};
        repeat (3)
            pct_plan.push_back(PCT_W'($urandom_range(0, 127)));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes and duplicates while the window fills, reset percentile
        send_sample(sample_t'(16'h8000));
        send_sample(sample_t'(16'h7FFF));
        send_sample(sample_t'(0));
        send_sample(sample_t'(-1));
        send_sample(sample_t'(1));
        send_sample(sample_t'(16'h7FFF));
        send_sample(sample_t'(16'h8000));
        send_sample(sample_t'(5));
        send_sample(sample_t'(5));
        send_sample(sample_t'(5));
        send_sample(sample_t'(-5));
        send_sample(sample_t'(100));
        send_sample(sample_t'(-100));
        send_sample(sample_t'(0));
        send_sample(sample_t'(0));
        send_sample(sample_t'(16'h5555));
        send_sample(sample_t'(16'hAAAA));

        foreach (pct_plan[p])
        begin
            drain();
            write_percentile(pct_plan[p]);
            // some phases run without idling; the last one never idles
            idle_on = (p == pct_plan.size() - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            repeat (PHASE_ITEMS)
                send_sample(pick_sample());
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("** sliding_window_percentile: PASSED **");
        else
            $display("** sliding_window_percentile: FAILED **");
        $finish;
    end

endmodule
